// ===== sv/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg: shared definitions for the byte ring FIFO
// Sizes, opcode and status codes, and the command and status groups that
// travel between the controller and the datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Store geometry and transfer limits.
  localparam int DEPTH     = 4096;
  localparam int MAX_BURST = 64;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int STS_W  = 2;
  localparam int LVL_W  = 13;

  // Derived widths.
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int WIDE_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } brf_op_e;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOSPACE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } brf_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic rd_issue;  // read the store at the read pointer
    logic load_ram;  // move the read data into the output register
  } brf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic underflow; // a get request asks for more than is stored
    logic get_last;  // the byte being loaded closes the get
    logic out_free;  // the output register can take a new result
  } brf_sts_t;

  // Limit a transfer length to the range one to MAX_BURST.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MAX_BURST)) begin
      res = LEN_W'(MAX_BURST);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // Report a byte count in the width of the fill level field.
  function automatic logic [LVL_W-1:0] lvl_of(input logic [CNT_W-1:0] cnt);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(cnt);
    return w[LVL_W-1:0];
  endfunction

endpackage

// ===== sv/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/brf_ctrl.sv =====
// ----------------------------------------------------------------------------
// brf_ctrl: request sequencer for the byte ring FIFO
// Takes requests while idle and walks a get through the store one byte per
// cycle, pacing the reads against the output register.
// ----------------------------------------------------------------------------
module brf_ctrl
  import brf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  output logic            in_stall_o,
  input  brf_sts_t        sts_i,
  output brf_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_GET  = 2'b10
  } brf_state_e;

  brf_state_e state_q, state_d;
  brf_op_e    op;

  assign op = brf_op_e'(opcode_i);

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = !sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
        if (cmd_o.accept && (op == OP_GET) && !sts_i.underflow) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_GET;
        end
      end
      S_GET: begin
        if (sts_i.out_free) begin
          cmd_o.load_ram = 1'b1;
          if (sts_i.get_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/brf_dp.sv =====
// ----------------------------------------------------------------------------
// brf_dp: datapath of the byte ring FIFO
// Holds the pointers, the byte count, the open put run and the output
// register, and owns the byte store.
// ----------------------------------------------------------------------------
module brf_dp
  import brf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [BYTE_W-1:0] data_in_i,
  input  brf_cmd_t          cmd_i,
  output brf_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] data_out_o,
  output logic [STS_W-1:0]  status_o,
  output logic [LVL_W-1:0]  fill_level_o,
  output logic              last_o
);

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  run_rem_q, run_rem_d;
  logic              run_acc_q, run_acc_d;
  logic [LEN_W-1:0]  get_rem_q, get_rem_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_data_q, out_data_d;
  logic [STS_W-1:0]  out_sts_q, out_sts_d;
  logic [LVL_W-1:0]  out_lvl_q, out_lvl_d;
  logic              out_last_q, out_last_d;

  brf_op_e           op;
  logic [LEN_W-1:0]  len_c;
  logic [CMP_W-1:0]  len_wide;
  logic [CMP_W-1:0]  cnt_wide;
  logic [CMP_W-1:0]  free_wide;
  logic              run_open;
  logic              acc_now;
  logic [LEN_W-1:0]  rem_next;
  logic              do_write;
  logic [CNT_W-1:0]  count_put;
  logic              out_taken;
  logic [BYTE_W-1:0] rdata;

  // Decode the request and the space checks.
  assign op        = brf_op_e'(opcode_i);
  assign len_c     = clamp_len(length_i);
  assign len_wide  = CMP_W'(len_c);
  assign cnt_wide  = CMP_W'(count_q);
  assign free_wide = CMP_W'(DEPTH) - cnt_wide;
  assign run_open  = (run_rem_q != '0);
  assign acc_now   = run_open ? run_acc_q : (free_wide >= len_wide);
  assign rem_next  = (run_open ? run_rem_q : len_c) - LEN_W'(1);
  assign do_write  = cmd_i.accept && (op == OP_PUT) && acc_now &&
                     (count_q != CNT_W'(DEPTH));
  assign count_put = do_write ? (count_q + CNT_W'(1)) : count_q;

  // Output register handshake.
  assign out_taken = out_valid_q && !out_stall_i;

  assign sts_o.underflow = (cnt_wide < len_wide);
  assign sts_o.get_last  = (get_rem_q == LEN_W'(1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Byte store.
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_ptr_q),
    .wdata_i (data_in_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Next values of the pointers, the count, the run and the output register.
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    run_rem_d   = run_rem_q;
    run_acc_d   = run_acc_q;
    get_rem_d   = get_rem_q;
    out_valid_d = out_taken ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    out_sts_d   = out_sts_q;
    out_lvl_d   = out_lvl_q;
    out_last_d  = out_last_q;

    if (cmd_i.accept) begin
      unique case (op)
        OP_PUT: begin
          run_rem_d = rem_next;
          run_acc_d = acc_now;
          count_d   = count_put;
          if (do_write) begin
            wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_q + PTR_W'(1));
          end
          if (rem_next == '0) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            out_sts_d   = acc_now ? ST_OK : ST_NOSPACE;
            out_lvl_d   = lvl_of(count_put);
            out_last_d  = 1'b1;
          end
        end
        OP_GET: begin
          if (sts_o.underflow) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            out_sts_d   = ST_UNDERFLOW;
            out_lvl_d   = lvl_of(count_q);
            out_last_d  = 1'b1;
          end else begin
            // The level after the whole get is shown in every result.
            count_d   = count_q - CNT_W'(len_c);
            get_rem_d = len_c;
          end
        end
        OP_CLEAR: begin
          rd_ptr_d    = '0;
          wr_ptr_d    = '0;
          count_d     = '0;
          run_rem_d   = '0;
          run_acc_d   = 1'b0;
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_sts_d   = ST_OK;
          out_lvl_d   = '0;
          out_last_d  = 1'b1;
        end
        OP_QUERY: begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_sts_d   = ST_OK;
          out_lvl_d   = lvl_of(count_q);
          out_last_d  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Advance the read pointer with each read of the store.
    if (cmd_i.rd_issue) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_q + PTR_W'(1));
    end

    // Present a byte of a get.
    if (cmd_i.load_ram) begin
      get_rem_d   = get_rem_q - LEN_W'(1);
      out_valid_d = 1'b1;
      out_data_d  = rdata;
      out_sts_d   = ST_OK;
      out_lvl_d   = lvl_of(count_q);
      out_last_d  = sts_o.get_last;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      run_rem_q   <= '0;
      run_acc_q   <= 1'b0;
      get_rem_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      run_rem_q   <= run_rem_d;
      run_acc_q   <= run_acc_d;
      get_rem_q   <= get_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_sts_q  <= out_sts_d;
    out_lvl_q  <= out_lvl_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign status_o     = out_sts_q;
  assign fill_level_o = out_lvl_q;
  assign last_o       = out_last_q;

endmodule

// ===== sv/byte_ring_fifo_all_or_nothing.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_all_or_nothing: circular byte store with whole-run transfers
// Top level joining the request sequencer and the datapath.
// ----------------------------------------------------------------------------
// A put, clear or query request is taken while the output register is free,
// so a run of put bytes can stream at one byte per cycle unless the output
// stalls; only the last byte of a run, a clear or a query produces a result.
// A get holds the input until its last byte is loaded: the accepting cycle
// issues the first read, and the registered read port of the store then
// delivers one byte per cycle into the output register while it is free. A
// get finding too few bytes answers at once with one underflow result. The
// store needs no reset clearing, so requests are taken from the first cycle.
module byte_ring_fifo_all_or_nothing
  import brf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [BYTE_W-1:0] data_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] data_out_o,
  output logic [STS_W-1:0]  status_o,
  output logic [LVL_W-1:0]  fill_level_o,
  output logic              last_o
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  // Request sequencer.
  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Pointers, count, store and output register.
  brf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .length_i     (length_i),
    .data_in_i    (data_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .fill_level_o (fill_level_o),
    .last_o       (last_o)
  );

endmodule
